/* design/assert_macros.svh */
// Assertion macros used by the checked top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* design/omrs_pkg.sv */
// Types, constants and request structs for the rank-select skip list.
package omrs_pkg;
    localparam int NODES     = 1024;
    localparam int LEVELS    = 16;
    localparam int NODE_W    = $clog2(NODES);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int LVLC_W    = $clog2(LEVELS + 1);
    localparam int LINK_AW   = $clog2(NODES * LEVELS);
    localparam logic [NODE_W-1:0] HEAD      = NODE_W'(1);
    localparam logic [15:0]       LFSR_SEED = 16'hACE1;
    localparam logic [15:0]       LFSR_MASK = 16'hB400;
    localparam logic [31:0]       TOTAL_CAP = 32'hFFFF_FFFE;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_RANK   = 3'd2,
        OP_KTH    = 3'd3,
        OP_PRED   = 3'd4,
        OP_SUCC   = 3'd5
    } op_e;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] key_value;
        logic [31:0]        position;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_key;
        logic [31:0]        result_rank;
        logic               answer_valid;
        logic               pool_full;
    } out_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        count;
        logic [LVLC_W-1:0]  level;
    } node_t;

    typedef struct packed {
        logic [NODE_W-1:0] link;
        logic [31:0]       span;
    } link_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        node_t             wdata;
        logic [NODE_W-1:0] raddr;
    } node_req_t;

    typedef struct packed {
        logic               we;
        logic [LINK_AW-1:0] waddr;
        link_t              wdata;
        logic [LINK_AW-1:0] raddr;
    } link_req_t;
endpackage

/* design/omrs_ram.sv */
// Generic single-write, single-read memory with a registered read port.
module omrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/omrs_ctrl.sv */
// Sequencer that walks, queries and relinks the skip list held in memory.
module omrs_ctrl import omrs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_t       s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_t      m_data,
    output node_req_t node_req,
    input  node_t     node_rdata,
    output link_req_t link_req,
    input  link_t     link_rdata
);
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_WRD, S_WLNK, S_WKEY, S_DEC, S_SPADJ, S_DRAW, S_INS,
        S_INS2, S_REM, S_REM2, S_SLNK, S_SKEY, S_KRD, S_KLNK, S_KKEY, S_OUT
    } state_t;

    function automatic logic [LINK_AW-1:0] link_addr(input logic [NODE_W-1:0] n,
                                                     input logic [LVL_W-1:0] h);
        link_addr = LINK_AW'(n) * LINK_AW'(LEVELS) + LINK_AW'(h);
    endfunction

    localparam logic [LVL_W-1:0] TOP = LVL_W'(LEVELS - 1);

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic [31:0]        pos_reg, pos_next;
    logic [LVL_W-1:0]   h_reg, h_next;
    logic [NODE_W-1:0]  i_reg, i_next;
    logic [NODE_W-1:0]  j_reg, j_next;
    logic [NODE_W-1:0]  used_reg, used_next;
    logic [31:0]        r_reg, r_next;
    logic [32:0]        c_reg, c_next;
    logic signed [31:0] cur_key_reg, cur_key_next;
    logic [31:0]        total_reg, total_next;
    logic [15:0]        lfsr_reg, lfsr_next;
    logic [LVLC_W-1:0]  lvl_reg, lvl_next;
    link_t              lnk_reg, lnk_next;
    node_t              hit_node_reg, hit_node_next;
    out_t               res_reg, res_next;
    out_t               m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;

    // Path record of the last walk, one entry per level.
    logic [NODE_W-1:0] upd_reg [LEVELS];
    logic [31:0]       acc_reg [LEVELS];
    link_t             nxt_reg [LEVELS];
    logic              rec_we;
    link_t             rec_link;

    logic              hit;
    logic [31:0]       down;
    logic [32:0]       c_sum;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign hit      = (nxt_reg[0].link != '0) && (hit_node_reg.key == key_reg);
    assign down     = acc_reg[0] - acc_reg[h_reg];
    assign c_sum    = c_reg + {1'b0, link_rdata.span};

    // Next-state and memory request logic.
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        h_next        = h_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        used_next     = used_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        cur_key_next  = cur_key_reg;
        total_next    = total_reg;
        lfsr_next     = lfsr_reg;
        lvl_next      = lvl_reg;
        lnk_next      = lnk_reg;
        hit_node_next = hit_node_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        node_req      = '0;
        link_req      = '0;
        rec_we        = 1'b0;
        rec_link      = lnk_reg;

        unique case (state_reg)
            S_CLR: begin
                link_req.we    = 1'b1;
                link_req.waddr = link_addr(HEAD, h_reg);
                if (h_reg == TOP) begin
                    state_next = S_IDLE;
                end else begin
                    h_next = h_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next  = s_data.op;
                    key_next = s_data.key_value;
                    pos_next = s_data.position;
                    i_next   = HEAD;
                    r_next   = '0;
                    c_next   = '0;
                    h_next   = TOP;
                    res_next = '0;
                    priority case (s_data.op)
                        OP_INSERT, OP_REMOVE, OP_RANK, OP_PRED, OP_SUCC: begin
                            state_next = S_WRD;
                        end
                        OP_KTH: begin
                            if (s_data.position == '0 || s_data.position > total_reg) begin
                                state_next = S_OUT;
                            end else begin
                                state_next = S_KRD;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            // Descent toward the key: link read, then key read of its target.
            S_WRD: begin
                link_req.raddr = link_addr(i_reg, h_reg);
                state_next     = S_WLNK;
            end
            S_WLNK: begin
                lnk_next = link_rdata;
                if (link_rdata.link != '0) begin
                    node_req.raddr = link_rdata.link;
                    state_next     = S_WKEY;
                end else begin
                    rec_we   = 1'b1;
                    rec_link = link_rdata;
                    if (h_reg == '0) begin
                        state_next = S_DEC;
                    end else begin
                        h_next     = h_reg - 1'b1;
                        state_next = S_WRD;
                    end
                end
            end
            S_WKEY: begin
                if (node_rdata.key < key_reg) begin
                    r_next       = r_reg + lnk_reg.span;
                    i_next       = lnk_reg.link;
                    cur_key_next = node_rdata.key;
                    state_next   = S_WRD;
                end else begin
                    rec_we = 1'b1;
                    if (h_reg == '0) begin
                        hit_node_next = node_rdata;
                        state_next    = S_DEC;
                    end else begin
                        h_next     = h_reg - 1'b1;
                        state_next = S_WRD;
                    end
                end
            end
            // Decide what the operation does once the path is known.
            S_DEC: begin
                h_next     = '0;
                state_next = S_OUT;
                priority case (op_reg)
                    OP_INSERT: begin
                        if (total_reg >= TOTAL_CAP) begin
                            state_next = S_OUT;
                        end else if (hit) begin
                            node_req.we    = 1'b1;
                            node_req.waddr = nxt_reg[0].link;
                            node_req.wdata = hit_node_reg;
                            node_req.wdata.count = hit_node_reg.count + 1'b1;
                            total_next = total_reg + 1'b1;
                            state_next = S_SPADJ;
                        end else if ({1'b0, used_reg} + 1'b1 >= (NODE_W + 1)'(NODES)) begin
                            res_next.pool_full = 1'b1;
                        end else begin
                            j_next     = used_reg + 1'b1;
                            used_next  = used_reg + 1'b1;
                            lvl_next   = LVLC_W'(1);
                            state_next = S_DRAW;
                        end
                    end
                    OP_REMOVE: begin
                        if (hit) begin
                            total_next = total_reg - 1'b1;
                            if (hit_node_reg.count > 32'd1) begin
                                node_req.we    = 1'b1;
                                node_req.waddr = nxt_reg[0].link;
                                node_req.wdata = hit_node_reg;
                                node_req.wdata.count = hit_node_reg.count - 1'b1;
                                state_next = S_SPADJ;
                            end else begin
                                state_next = S_REM;
                            end
                        end
                    end
                    OP_RANK: begin
                        res_next.result_rank  = acc_reg[0] + 1'b1;
                        res_next.answer_valid = 1'b1;
                    end
                    OP_PRED: begin
                        if (i_reg != HEAD) begin
                            res_next.result_key   = cur_key_reg;
                            res_next.answer_valid = 1'b1;
                        end
                    end
                    OP_SUCC: begin
                        if (hit) begin
                            link_req.raddr = link_addr(nxt_reg[0].link, '0);
                            state_next     = S_SLNK;
                        end else if (nxt_reg[0].link != '0) begin
                            res_next.result_key   = hit_node_reg.key;
                            res_next.answer_valid = 1'b1;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            // Span of every path link moves by one for a duplicate change.
            S_SPADJ: begin
                link_req.we    = 1'b1;
                link_req.waddr = link_addr(upd_reg[h_reg], h_reg);
                link_req.wdata = nxt_reg[h_reg];
                link_req.wdata.span = (op_reg == OP_INSERT) ? nxt_reg[h_reg].span + 1'b1
                                                            : nxt_reg[h_reg].span - 1'b1;
                if (h_reg == TOP) begin
                    res_next.answer_valid = 1'b1;
                    state_next = S_OUT;
                end else begin
                    h_next = h_reg + 1'b1;
                end
            end
            // Level draw: one register step per cycle.
            S_DRAW: begin
                if (lvl_reg < LVLC_W'(LEVELS)) begin
                    lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : 16'h0000);
                end
                if (lvl_reg < LVLC_W'(LEVELS) && lfsr_reg[0]) begin
                    lvl_next = lvl_reg + 1'b1;
                end else begin
                    node_req.we          = 1'b1;
                    node_req.waddr       = j_reg;
                    node_req.wdata.key   = key_reg;
                    node_req.wdata.count = 32'd1;
                    node_req.wdata.level = lvl_reg;
                    total_next = total_reg + 1'b1;
                    state_next = S_INS;
                end
            end
            // Splice the new node in, level by level.
            S_INS: begin
                link_req.we = 1'b1;
                if (LVLC_W'(h_reg) >= lvl_reg) begin
                    link_req.waddr      = link_addr(upd_reg[h_reg], h_reg);
                    link_req.wdata      = nxt_reg[h_reg];
                    link_req.wdata.span = nxt_reg[h_reg].span + 1'b1;
                    if (h_reg == TOP) begin
                        res_next.answer_valid = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        h_next = h_reg + 1'b1;
                    end
                end else begin
                    link_req.waddr      = link_addr(j_reg, h_reg);
                    link_req.wdata      = nxt_reg[h_reg];
                    link_req.wdata.span = nxt_reg[h_reg].span - down;
                    state_next          = S_INS2;
                end
            end
            S_INS2: begin
                link_req.we         = 1'b1;
                link_req.waddr      = link_addr(upd_reg[h_reg], h_reg);
                link_req.wdata.link = j_reg;
                link_req.wdata.span = down + 1'b1;
                if (h_reg == TOP) begin
                    res_next.answer_valid = 1'b1;
                    state_next = S_OUT;
                end else begin
                    h_next     = h_reg + 1'b1;
                    state_next = S_INS;
                end
            end
            // Unlink the removed node, level by level.
            S_REM: begin
                if (LVLC_W'(h_reg) >= hit_node_reg.level) begin
                    link_req.we         = 1'b1;
                    link_req.waddr      = link_addr(upd_reg[h_reg], h_reg);
                    link_req.wdata      = nxt_reg[h_reg];
                    link_req.wdata.span = nxt_reg[h_reg].span - 1'b1;
                    if (h_reg == TOP) begin
                        res_next.answer_valid = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        h_next = h_reg + 1'b1;
                    end
                end else begin
                    link_req.raddr = link_addr(nxt_reg[0].link, h_reg);
                    state_next     = S_REM2;
                end
            end
            S_REM2: begin
                link_req.we         = 1'b1;
                link_req.waddr      = link_addr(upd_reg[h_reg], h_reg);
                link_req.wdata.link = link_rdata.link;
                link_req.wdata.span = nxt_reg[h_reg].span + link_rdata.span - 1'b1;
                if (h_reg == TOP) begin
                    res_next.answer_valid = 1'b1;
                    state_next = S_OUT;
                end else begin
                    h_next     = h_reg + 1'b1;
                    state_next = S_REM;
                end
            end
            // Successor past an exact match.
            S_SLNK: begin
                if (link_rdata.link != '0) begin
                    node_req.raddr = link_rdata.link;
                    state_next     = S_SKEY;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_SKEY, S_KKEY: begin
                res_next.result_key   = node_rdata.key;
                res_next.answer_valid = 1'b1;
                state_next            = S_OUT;
            end
            // Descent by position for the kth smallest query.
            S_KRD: begin
                link_req.raddr = link_addr(i_reg, h_reg);
                state_next     = S_KLNK;
            end
            S_KLNK: begin
                if (link_rdata.link != '0 && c_sum < {1'b0, pos_reg}) begin
                    c_next     = c_sum;
                    i_next     = link_rdata.link;
                    state_next = S_KRD;
                end else if (h_reg != '0) begin
                    h_next     = h_reg - 1'b1;
                    state_next = S_KRD;
                end else if (link_rdata.link != '0) begin
                    node_req.raddr = link_rdata.link;
                    state_next     = S_KKEY;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            h_reg       <= '0;
            used_reg    <= HEAD;
            total_reg   <= '0;
            lfsr_reg    <= LFSR_SEED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            h_reg       <= h_next;
            used_reg    <= used_next;
            total_reg   <= total_next;
            lfsr_reg    <= lfsr_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        pos_reg      <= pos_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        r_reg        <= r_next;
        c_reg        <= c_next;
        cur_key_reg  <= cur_key_next;
        lvl_reg      <= lvl_next;
        lnk_reg      <= lnk_next;
        hit_node_reg <= hit_node_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    // Path record written as each level of the walk closes.
    always_ff @(posedge aclk) begin
        if (rec_we) begin
            upd_reg[h_reg] <= i_reg;
            acc_reg[h_reg] <= r_reg;
            nxt_reg[h_reg] <= rec_link;
        end
    end
endmodule

/* design/ordered_multiset_rank_select.sv */
// Ordered multiset with rank and select, kept as an indexable skip list in two memories.
// The walk reads the link at each level and, where it points to a node, that node's key;
// a relink then writes each level's path link, with an extra write for the new node's own
// link where it has that level, or a link read where the removed node has it, after a level
// draw for a new key. Requests are taken one at a time, and after reset the head row is
// cleared before any request is taken.
`include "assert_macros.svh"
module ordered_multiset_rank_select import omrs_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);
    node_req_t node_req;
    link_req_t link_req;
    node_t     node_rdata;
    link_t     link_rdata;

    // Per-node key, count and level.
    omrs_ram #(.WIDTH($bits(node_t)), .DEPTH(NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (node_req.we),
        .waddr (node_req.waddr),
        .wdata (node_req.wdata),
        .raddr (node_req.raddr),
        .rdata (node_rdata)
    );

    // Forward links and spans, one row of levels per node.
    omrs_ram #(.WIDTH($bits(link_t)), .DEPTH(NODES * LEVELS)) u_link_ram (
        .aclk  (aclk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .raddr (link_req.raddr),
        .rdata (link_rdata)
    );

    omrs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .node_req   (node_req),
        .node_rdata (node_rdata),
        .link_req   (link_req),
        .link_rdata (link_rdata)
    );

    // Requests are handled one at a time.
    `CHK_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "request taken while busy")
    // A refused insert never reports success.
    `CHK_SAME(a_full_not_valid, m_valid && m_data.pool_full, !m_data.answer_valid, "full and valid")
    // A rank answer is always valid.
    `CHK_SAME(a_rank_valid, m_valid && m_data.result_rank != '0, m_data.answer_valid, "rank invalid")
    // No memory write while waiting for a request.
    `CHK_SAME(a_idle_quiet, s_ready, !node_req.we && !link_req.we, "write while idle")
endmodule

/* dv/ordered_multiset_rank_select_tb.sv */
// Self-checking testbench for the skip-list rank and select multiset.
module ordered_multiset_rank_select_tb;
    import omrs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Predicted contents: distinct keys in ascending order with their counts.
    logic signed [31:0] set_keys[$];
    int unsigned        set_counts[$];
    int unsigned        slots_used = 1;
    out_t               pending_answers[$];

    int  mismatches = 0;
    int  requests_sent = 0;
    int  answers_seen = 0;
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    int  stall_left = 0;
    int  refusals = 0;

    ordered_multiset_rank_select dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    // Cycle counter with a hard limit on the run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d answers outstanding", cycles,
                     pending_answers.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint unsigned multiset_size();
        longint unsigned t;
        t = 0;
        foreach (set_counts[i]) t += set_counts[i];
        return t;
    endfunction

    // Work out the answer to one request and apply its effect to the prediction.
    function automatic out_t predict_answer(in_t r);
        out_t a;
        int hit, ins_at;
        longint unsigned below, acc;
        a = '0;
        hit = -1;
        below = 0;
        ins_at = set_keys.size();
        foreach (set_keys[i]) begin
            if (set_keys[i] < r.key_value) below += set_counts[i];
            if (set_keys[i] == r.key_value) hit = i;
            if (set_keys[i] > r.key_value && ins_at == set_keys.size()) ins_at = i;
        end
        case (r.op)
            OP_INSERT: begin
                if (multiset_size() < TOTAL_CAP) begin
                    if (hit >= 0) begin
                        set_counts[hit]++;
                        a.answer_valid = 1'b1;
                    end else if (slots_used + 1 >= NODES) begin
                        a.pool_full = 1'b1;
                    end else begin
                        slots_used++;
                        set_keys.insert(ins_at, r.key_value);
                        set_counts.insert(ins_at, 1);
                        a.answer_valid = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    a.answer_valid = 1'b1;
                    if (set_counts[hit] > 1) begin
                        set_counts[hit]--;
                    end else begin
                        set_keys.delete(hit);
                        set_counts.delete(hit);
                    end
                end
            end
            OP_RANK: begin
                a.result_rank = 32'(below + 1);
                a.answer_valid = 1'b1;
            end
            OP_KTH: begin
                if (r.position != 0 && r.position <= multiset_size()) begin
                    acc = 0;
                    foreach (set_keys[i]) begin
                        acc += set_counts[i];
                        if (acc >= r.position && !a.answer_valid) begin
                            a.result_key = set_keys[i];
                            a.answer_valid = 1'b1;
                        end
                    end
                end
            end
            OP_PRED: begin
                foreach (set_keys[i])
                    if (set_keys[i] < r.key_value) begin
                        a.result_key = set_keys[i];
                        a.answer_valid = 1'b1;
                    end
            end
            OP_SUCC: begin
                if (ins_at < set_keys.size()) begin
                    a.result_key = set_keys[ins_at];
                    a.answer_valid = 1'b1;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("Mismatch on answer %0d, %s: got %h, expected %h", answers_seen, field,
                 got, want);
        mismatches++;
    endtask

    // Compare every answer taken from the block with the oldest prediction.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $display("Answer %0d arrived with none predicted", answers_seen);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (m_data.result_key !== want.result_key)
                    report_mismatch("result_key", m_data.result_key, want.result_key);
                if (m_data.result_rank !== want.result_rank)
                    report_mismatch("result_rank", m_data.result_rank, want.result_rank);
                if (m_data.answer_valid !== want.answer_valid)
                    report_mismatch("answer_valid", m_data.answer_valid, want.answer_valid);
                if (m_data.pool_full !== want.pool_full)
                    report_mismatch("pool_full", m_data.pool_full, want.pool_full);
            end
            answers_seen++;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off when asked for.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            m_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Offer one request from a falling edge and predict its answer on acceptance.
    task automatic send_request(logic [2:0] op, logic [31:0] key, logic [31:0] position);
        in_t r;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        r.op = op;
        r.key_value = key;
        r.position = position;
        s_data = r;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_answers.push_back(predict_answer(r));
        if (op == OP_INSERT && pending_answers[$].pool_full) refusals++;
        requests_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0001;
            default: return 32'($signed($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    function automatic logic [31:0] pick_position();
        int unsigned n;
        n = 32'(multiset_size());
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return n + 1;
            default: return $urandom_range(0, n + 1);
        endcase
    endfunction

    function automatic logic [2:0] pick_op();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 30) return OP_INSERT;
        if (p < 45) return OP_REMOVE;
        if (p < 58) return OP_RANK;
        if (p < 72) return OP_KTH;
        if (p < 84) return OP_PRED;
        if (p < 96) return OP_SUCC;
        return 3'($urandom_range(6, 7));
    endfunction

    // Empty queries, extreme keys, duplicates, removal and unused op codes.
    task automatic test_directed();
        send_request(OP_RANK, 32'd5, 0);
        send_request(OP_KTH, 0, 32'd1);
        send_request(OP_PRED, 32'd0, 0);
        send_request(OP_SUCC, 32'd0, 0);
        send_request(OP_REMOVE, 32'd3, 0);
        send_request(OP_INSERT, 32'h8000_0000, 0);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 0);
        send_request(OP_INSERT, 32'd0, 0);
        send_request(OP_INSERT, 32'd0, 0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 0);
        send_request(OP_RANK, 32'h7FFF_FFFF, 0);
        send_request(OP_RANK, 32'h8000_0000, 0);
        send_request(OP_KTH, 0, 32'd0);
        send_request(OP_KTH, 0, 32'd1);
        send_request(OP_KTH, 0, 32'd4);
        send_request(OP_KTH, 0, 32'd6);
        send_request(OP_KTH, 0, 32'hFFFF_FFFF);
        send_request(OP_PRED, 32'h8000_0000, 0);
        send_request(OP_SUCC, 32'h7FFF_FFFF, 0);
        send_request(OP_SUCC, 32'h8000_0000, 0);
        send_request(OP_REMOVE, 32'd0, 0);
        send_request(OP_REMOVE, 32'h8000_0000, 0);
        send_request(OP_PRED, 32'd0, 0);
        send_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(3'd7, 32'd1, 32'd1);
    endtask

    task automatic test_random_mix(int count);
        repeat (count) send_request(pick_op(), pick_key(), pick_position());
    endtask

    // The receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random_mix(40);
    endtask

    // Fill every node slot with fresh keys, then try more and query the result.
    task automatic test_pool_exhaustion();
        int unsigned fresh;
        fresh = 32'h1000_0000;
        while (slots_used + 1 < NODES) begin
            send_request(OP_INSERT, fresh, 0);
            fresh += 32'd7;
        end
        send_request(OP_INSERT, fresh, 0);
        send_request(OP_INSERT, 32'h8000_0000, 0);
        send_request(OP_INSERT, 32'h0FFF_FFFF, 0);
        send_request(OP_KTH, 0, 32'(multiset_size()));
        send_request(OP_RANK, fresh, 0);
        send_request(OP_REMOVE, 32'h1000_0000, 0);
        send_request(OP_INSERT, 32'h1000_0000, 0);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random_mix(330);
        test_backpressure();
        test_pool_exhaustion();
        calm = 1'b1;
        test_random_mix(80);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Covered %0d requests and %0d answers, including %0d refused inserts,",
                 requests_sent, answers_seen, refusals);
        $display("with stall bursts, a long receiver hold-off and a full node pool.");
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
